### sv/tmbc_pkg.sv
// Package for the tile map box collision block.
// Holds sizes, CSR indices, state encoding and the division step count used by the top module.
package tmbc_pkg;

   localparam int MaxColumns = 64;
   localparam int MaxRows    = 64;
   localparam int MapDepth   = MaxColumns * MaxRows;
   localparam int AddrW      = $clog2(MapDepth);
   localparam int ColW       = $clog2(MaxColumns + 1);
   localparam int RowW       = $clog2(MaxRows + 1);
   localparam int DivW       = 20;
   localparam int DivSteps   = DivW;

   localparam logic [1:0] CsrTileWidth  = 2'd0;
   localparam logic [1:0] CsrTileHeight = 2'd1;
   localparam logic [1:0] CsrMapColumns = 2'd2;
   localparam logic [1:0] CsrMapRows    = 2'd3;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_V_INIT,
      ST_V_LDIV,
      ST_V_RDIV,
      ST_V_COL,
      ST_V_TDIV,
      ST_V_BDIV,
      ST_V_ADDR,
      ST_V_READ,
      ST_V_FIX,
      ST_H_TDIV,
      ST_H_BDIV,
      ST_H_ROW,
      ST_H_LDIV,
      ST_H_RDIV,
      ST_H_ADDR,
      ST_H_READ,
      ST_H_FIX,
      ST_EDGE,
      ST_DONE
   } state_type;

endpackage

### sv/tile_map_box_collision_top.sv
// Tile map box collision: a one-bit tile map, a restoring divider and a sequencer.
// Depends on tmbc_pkg.
//
// A tile write beat gives no result beat. A query uses one shared restoring
// divider for each division by the tile size. A query divides twice for each
// tile column and each tile row of the box, and probes a second tile in a column
// or row where the first tile probed is empty. After reset the map is cleared by
// a pass over all 4096 tiles, one tile a cycle, and no beat is taken during the
// pass. A result waits in an output register, so the next beat can be taken
// before the result is. A query that ends while an older result still waits
// holds until that result is taken.
module tile_map_box_collision_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_mode,
   input  logic [11:0] req_tile_index,
   input  logic        req_tile_is_solid,
   input  logic [14:0] req_box_x,
   input  logic [14:0] req_box_y,
   input  logic [9:0]  req_box_width,
   input  logic [9:0]  req_box_height,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic signed [15:0] rsp_fixed_x,
   output logic signed [15:0] rsp_fixed_y,
   output logic        rsp_hit_bottom,
   output logic        rsp_hit_top,
   output logic        rsp_hit_left,
   output logic        rsp_hit_right,
   output logic        rsp_past_right_edge,
   output logic        rsp_below_bottom_edge,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [8:0]  csr_data
);
   import tmbc_pkg::*;

   state_type state_ff, state_in;

   logic [8:0] tw_ff, th_ff;
   logic [6:0] cols_cfg_ff, rows_cfg_ff;

   logic        map_mem [MapDepth];
   logic        rd_ff;
   logic        clr_busy_ff;
   logic [AddrW-1:0] clr_addr_ff;

   logic signed [19:0] x_ff, x_in, y_ff, y_in;
   logic [9:0]  w_ff, h_ff;
   logic signed [19:0] a_ff, a_in, b_ff, b_in;   // loop limit, near tile
   logic signed [19:0] c_ff, c_in;               // loop counter
   logic        hb_ff, hb_in, ht_ff, ht_in, hl_ff, hl_in, hr_ff, hr_in;
   logic        phase_ff, phase_in;              // 0 probes first tile, 1 second tile
   logic [AddrW-1:0] addr_ff, addr_in;
   logic        addr_ok_ff, addr_ok_in;
   logic signed [19:0] top_ff, far_ff, edge_x_ff;

   // Shared restoring divider, unsigned magnitude with sign fixup.
   logic [DivW-1:0] dq_ff, dr_ff, dd_ff;
   logic [4:0]      dcnt_ff;
   logic            dneg_ff, dbusy_ff;
   logic            dstart;
   logic signed [19:0] dnum;
   logic [8:0]      dden;
   logic [DivW:0]   dtrial;
   logic signed [19:0] dquot;

   logic        rsp_valid_ff;
   logic        rsp_load;
   logic signed [15:0] rx_ff, ry_ff;
   logic [5:0]  rflag_ff;

   logic [8:0]  tw, th;
   logic [6:0]  cols, rows;
   logic signed [19:0] mul_a;
   logic [8:0]  mul_b;
   logic signed [19:0] prod;
   logic signed [19:0] pc, pr;
   logic signed [19:0] x_end, y_end;
   logic        accept;

   assign tw   = (tw_ff == 9'd0) ? 9'd1 : tw_ff;
   assign th   = (th_ff == 9'd0) ? 9'd1 : th_ff;
   assign cols = (cols_cfg_ff == 7'd0) ? 7'd1 :
                 (cols_cfg_ff > 7'(MaxColumns)) ? 7'(MaxColumns) : cols_cfg_ff;
   assign rows = (rows_cfg_ff == 7'd0) ? 7'd1 :
                 (rows_cfg_ff > 7'(MaxRows)) ? 7'(MaxRows) : rows_cfg_ff;

   assign req_ready = (state_ff == ST_IDLE) && !clr_busy_ff;
   assign accept    = req_valid && req_ready;
   assign rsp_load  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tw_ff <= 9'd32;
         th_ff <= 9'd32;
         cols_cfg_ff <= 7'd64;
         rows_cfg_ff <= 7'd64;
      end else if (csr_write) begin
         unique case (csr_index)
            CsrTileWidth:  tw_ff <= csr_data;
            CsrTileHeight: th_ff <= csr_data;
            CsrMapColumns: cols_cfg_ff <= csr_data[6:0];
            CsrMapRows:    rows_cfg_ff <= csr_data[6:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == AddrW'(MapDepth - 1)) begin
            clr_busy_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         map_mem[clr_addr_ff] <= 1'b0;
      end else if (accept && !req_mode) begin
         map_mem[req_tile_index[AddrW-1:0]] <= req_tile_is_solid;
      end
      rd_ff <= map_mem[addr_ff];
   end

   // Divider operands, chosen by the state that starts the division.
   always_comb begin
      dnum = x_ff;
      dden = tw;
      unique case (state_ff)
         ST_V_INIT, ST_H_ROW: begin dnum = x_ff; dden = tw; end
         ST_V_LDIV, ST_H_LDIV: begin dnum = x_ff + 20'(w_ff) - 20'sd1; dden = tw; end
         ST_V_COL: begin dnum = y_ff; dden = th; end
         ST_V_TDIV, ST_H_TDIV: begin dnum = y_ff + 20'(h_ff) - 20'sd1; dden = th; end
         default: ;
      endcase
   end

   assign dtrial = {dr_ff, dq_ff[DivW-1]} - {{(DivW-8){1'b0}}, dd_ff[8:0]};
   assign dquot  = dneg_ff ? -$signed(dq_ff) : $signed(dq_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         dbusy_ff <= 1'b0;
      end else if (dstart) begin
         dbusy_ff <= 1'b1;
         dcnt_ff  <= 5'(DivSteps);
         dneg_ff  <= dnum[19];
         dq_ff    <= dnum[19] ? DivW'(-dnum) : DivW'(dnum);
         dr_ff    <= '0;
         dd_ff    <= DivW'(dden);
      end else if (dbusy_ff) begin
         if (dcnt_ff == 5'd0) begin
            dbusy_ff <= 1'b0;
         end else begin
            dcnt_ff <= dcnt_ff - 5'd1;
            if (!dtrial[DivW]) begin
               dr_ff <= dtrial[DivW-1:0];
               dq_ff <= {dq_ff[DivW-2:0], 1'b1};
            end else begin
               dr_ff <= {dr_ff[DivW-2:0], dq_ff[DivW-1]};
               dq_ff <= {dq_ff[DivW-2:0], 1'b0};
            end
         end
      end
   end

   logic div_done;
   assign div_done = dbusy_ff && (dcnt_ff == 5'd0);

   // Shared multiplier by tile size.
   always_comb begin
      mul_a = a_ff;
      mul_b = th;
      unique case (state_ff)
         ST_V_FIX: begin mul_a = phase_ff ? top_ff : b_ff; mul_b = th; end
         ST_H_FIX: begin mul_a = phase_ff ? far_ff : b_ff; mul_b = tw; end
         ST_EDGE:  begin mul_a = 20'(cols); mul_b = tw; end
         default: ;
      endcase
   end
   assign prod = 20'(mul_a * $signed({1'b0, mul_b}));

   always_comb begin
      state_in = state_ff;
      x_in = x_ff; y_in = y_ff;
      a_in = a_ff; b_in = b_ff; c_in = c_ff;
      hb_in = hb_ff; ht_in = ht_ff; hl_in = hl_ff; hr_in = hr_ff;
      phase_in = phase_ff;
      addr_in = addr_ff; addr_ok_in = addr_ok_ff;
      dstart = 1'b0;
      pc = c_ff; pr = b_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && req_mode) begin
               x_in = 20'(req_box_x);
               y_in = 20'(req_box_y);
               hb_in = 1'b0; ht_in = 1'b0; hl_in = 1'b0; hr_in = 1'b0;
               state_in = ST_V_INIT;
            end
         end
         ST_V_INIT: begin
            dstart = 1'b1;
            state_in = ST_V_LDIV;
         end
         ST_V_LDIV: if (div_done) begin
            c_in = dquot; dstart = 1'b1; state_in = ST_V_RDIV;
         end
         ST_V_RDIV: if (div_done) begin
            a_in = dquot; state_in = ST_V_COL;
         end
         ST_V_COL: begin
            if (c_ff > a_ff) begin
               dstart = 1'b1; state_in = ST_H_TDIV;
            end else begin
               dstart = 1'b1; state_in = ST_V_TDIV; phase_in = 1'b0;
            end
         end
         ST_V_TDIV: if (div_done) begin
            x_in = x_ff; b_in = dquot; dstart = 1'b1; state_in = ST_V_BDIV;
         end
         ST_V_BDIV: if (div_done) begin
            b_in = dquot; c_in = c_ff;
            state_in = ST_V_ADDR;
         end
         ST_V_ADDR: begin
            pc = c_ff;
            pr = phase_ff ? top_ff : b_ff;
            addr_ok_in = (pc >= 0) && (pr >= 0) && (pc < 20'(cols)) && (pr < 20'(rows));
            addr_in = AddrW'(pr * 20'(cols) + pc);
            state_in = ST_V_READ;
         end
         ST_V_READ: state_in = ST_V_FIX;
         ST_V_FIX: begin
            if (rd_ff && addr_ok_ff) begin
               if (!phase_ff) begin
                  y_in = prod - 20'(h_ff); hb_in = 1'b1;
               end else begin
                  y_in = prod + 20'(th); ht_in = 1'b1;
               end
               c_in = c_ff + 20'sd1; state_in = ST_V_COL;
            end else if (!phase_ff) begin
               phase_in = 1'b1; state_in = ST_V_ADDR;
            end else begin
               c_in = c_ff + 20'sd1; state_in = ST_V_COL;
            end
         end
         ST_H_TDIV: if (div_done) begin
            c_in = dquot; dstart = 1'b1; state_in = ST_H_BDIV;
         end
         ST_H_BDIV: if (div_done) begin
            a_in = dquot; state_in = ST_H_ROW;
         end
         ST_H_ROW: begin
            if (c_ff > a_ff) begin
               state_in = ST_EDGE;
            end else begin
               dstart = 1'b1; state_in = ST_H_LDIV; phase_in = 1'b0;
            end
         end
         ST_H_LDIV: if (div_done) begin
            b_in = dquot; dstart = 1'b1; state_in = ST_H_RDIV;
         end
         ST_H_RDIV: if (div_done) begin
            b_in = b_ff; state_in = ST_H_ADDR;
         end
         ST_H_ADDR: begin
            pr = c_ff;
            pc = phase_ff ? far_ff : b_ff;
            addr_ok_in = (pc >= 0) && (pr >= 0) && (pc < 20'(cols)) && (pr < 20'(rows));
            addr_in = AddrW'(pr * 20'(cols) + pc);
            state_in = ST_H_READ;
         end
         ST_H_READ: state_in = ST_H_FIX;
         ST_H_FIX: begin
            if (rd_ff && addr_ok_ff) begin
               if (!phase_ff) begin
                  x_in = prod + 20'(tw); hl_in = 1'b1;
               end else begin
                  x_in = prod - 20'(w_ff); hr_in = 1'b1;
               end
               c_in = c_ff + 20'sd1; state_in = ST_H_ROW;
            end else if (!phase_ff) begin
               phase_in = 1'b1; state_in = ST_H_ADDR;
            end else begin
               c_in = c_ff + 20'sd1; state_in = ST_H_ROW;
            end
         end
         ST_EDGE: state_in = ST_DONE;
         ST_DONE: if (rsp_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Second operand registers: top row, far column and the map pixel width.
   always_ff @(posedge clock) begin
      if (state_ff == ST_V_TDIV && div_done) top_ff <= dquot;
      if (state_ff == ST_H_RDIV && div_done) far_ff <= dquot;
      if (state_ff == ST_EDGE) edge_x_ff <= prod;
   end

   logic signed [19:0] rows_px;
   assign rows_px = 20'(20'(rows) * $signed({1'b0, th}));
   assign x_end   = x_ff + $signed(20'(w_ff));
   assign y_end   = y_ff + $signed(20'(h_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_DONE && rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rx_ff <= x_ff[15:0];
            ry_ff <= y_ff[15:0];
            rflag_ff <= {hb_ff, ht_ff, hl_ff, hr_ff,
                         x_end > edge_x_ff,
                         y_end > rows_px};
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; y_ff <= y_in;
      a_ff <= a_in; b_ff <= b_in; c_ff <= c_in;
      hb_ff <= hb_in; ht_ff <= ht_in; hl_ff <= hl_in; hr_ff <= hr_in;
      phase_ff <= phase_in;
      addr_ff <= addr_in; addr_ok_ff <= addr_ok_in;
      if (accept) begin
         w_ff <= req_box_width;
         h_ff <= req_box_height;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_fixed_x = rx_ff;
   assign rsp_fixed_y = ry_ff;
   assign {rsp_hit_bottom, rsp_hit_top, rsp_hit_left, rsp_hit_right,
           rsp_past_right_edge, rsp_below_bottom_edge} = rflag_ff;

`ifndef SYNTHESIS
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !req_ready) else $error("accepted while busy");
   a_div_start_idle: assert property (@(posedge clock) disable iff (reset)
      dstart |-> !dbusy_ff || div_done) else $error("divider restarted mid-run");
   a_rsp_after_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE)) else $error("stray beat");
`endif

endmodule
